>>> design/rsdes_pkg.sv
// Shared types and constants for the RTCP SDES item parser.
// No dependencies; every other design file imports this package.
package rsdes_pkg;

    localparam int OFF_W = 18;

    localparam logic [7:0] SDES_TYPE_END = 8'h00;
    localparam logic [1:0] ALIGN_MASK    = 2'h3;

    // Status codes reported with packet_done
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SSRC_SHORT = 2'd1;
    localparam logic [1:0] ST_LEN_PAST   = 2'd2;
    localparam logic [1:0] ST_BUF_CUT    = 2'd3;

    typedef enum logic [6:0] {
        PH_HDR  = 7'b0000001,
        PH_SSRC = 7'b0000010,
        PH_TYPE = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_PAD  = 7'b0100000,
        PH_DONE = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       buffer_last;
    } t_in;

    typedef struct packed {
        logic [31:0] chunk_ssrc;
        logic [7:0]  item_type;
        logic [7:0]  item_length;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        item_end;
        logic        packet_done;
        logic [1:0]  status;
    } t_out;

endpackage

>>> design/rtcp_sdes_item_parser_core.sv
// Top level of the RTCP SDES item parser: input register, parse logic, result queue.
// Depends on rsdes_pkg, rsdes_parse and rsdes_skid.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------------
//  request  | i_req_valid  | o_req_ready  | i_req (t_in: byte, last)
//  result   | o_res_valid  | i_res_ready  | o_res (t_out)
//
// One byte per cycle while the result queue has room; results go out from the queue.
// Bytes that report nothing (header, SSRC, type, pad) leave no result behind.
// o_req_ready comes from registers only: it drops when the input stage holds a byte
// and the two-entry result queue is full.
// i_rst_n is synchronous and returns the parser to the packet header.
module rtcp_sdes_item_parser_core
    import rsdes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_in  i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_out o_res
);

    logic r_in_valid;
    t_in  r_in;
    logic q_full;
    logic fire;
    logic emit;
    t_out res;

    assign fire        = r_in_valid && !q_full;
    assign o_req_ready = !r_in_valid || !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) r_in <= i_req;
    end

    rsdes_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .o_emit  (emit),
        .o_res   (res)
    );

    rsdes_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire && emit),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (o_res)
    );

endmodule

>>> design/rsdes_parse.sv
// Parse state machine: walks header, chunk SSRCs, items and padding one byte per request.
// Depends on rsdes_pkg for the phase encoding, payload structs and status codes.
module rsdes_parse
    import rsdes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_req,
    output logic o_emit,
    output t_out o_res
);

    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] r_lim, n_lim;
    logic [4:0]       r_ctgt, n_ctgt;
    logic [4:0]       r_cseen, n_cseen;
    logic [31:0]      r_ssrc, n_ssrc;
    t_phase           r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_rem, n_rem;

    logic [7:0]       b;
    logic             last;
    logic             at_end;
    logic             borrow;
    logic [OFF_W-1:0] diff;
    logic [7:0]       rem_inc;
    logic [4:0]       cseen_inc;
    logic [1:0]       pad_cnt;
    logic             fin;
    logic [1:0]       fin_st;
    logic             active;
    logic             emit;
    logic             bval;
    logic             iend;
    logic [7:0]       dbyte;

    assign b         = i_req.pkt_byte;
    assign last      = i_req.buffer_last;
    assign at_end    = (r_off == r_lim);
    assign {borrow, diff} = {1'b0, r_lim} - {1'b0, r_off};
    assign rem_inc   = r_rem + 8'd1;
    assign cseen_inc = r_cseen + 5'd1;
    assign pad_cnt   = 2'd3 - (r_off[1:0] & ALIGN_MASK);

    always_comb begin
        n_off   = r_off;
        n_lim   = r_lim;
        n_ctgt  = r_ctgt;
        n_cseen = r_cseen;
        n_ssrc  = r_ssrc;
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_rem   = r_rem;
        fin     = 1'b0;
        fin_st  = ST_OK;
        active  = 1'b0;
        emit    = 1'b0;
        bval    = 1'b0;
        iend    = 1'b0;
        dbyte   = 8'd0;

        unique case (r_phase)
            PH_HDR: begin
                active = 1'b1;
                if (r_off == '0) n_ctgt = b[4:0];
                if (r_off == OFF_W'(2)) n_len = b;
                if (r_off >= OFF_W'(3)) begin
                    n_lim = {r_len, b, 2'b11};
                    n_len = 8'd0;
                    if (({r_len, b} == 16'd0) || last) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = PH_SSRC;
                        n_rem   = 8'd0;
                    end
                end else if (last) begin
                    fin    = 1'b1;
                    fin_st = ST_SSRC_SHORT;
                end
            end
            PH_SSRC: begin
                active = 1'b1;
                // too few packet bytes left for a whole SSRC
                if ((r_rem == 8'd0) && !borrow && (diff < OFF_W'(3))) begin
                    fin    = 1'b1;
                    fin_st = ST_SSRC_SHORT;
                end else begin
                    n_ssrc = {r_ssrc[23:0], b};
                    n_rem  = rem_inc;
                    if (rem_inc >= 8'd4) begin
                        n_rem   = 8'd0;
                        n_phase = PH_TYPE;
                        if (at_end || last) fin = 1'b1;
                    end else if (last) begin
                        fin    = 1'b1;
                        fin_st = ST_SSRC_SHORT;
                    end
                end
            end
            PH_TYPE: begin
                active = 1'b1;
                n_type = b;
                if (at_end || last) begin
                    fin = 1'b1;
                end else if (b == SDES_TYPE_END) begin
                    n_len   = 8'd0;
                    n_cseen = cseen_inc;
                    if (cseen_inc >= r_ctgt) begin
                        fin = 1'b1;
                    end else begin
                        n_rem   = {6'd0, pad_cnt};
                        n_phase = (pad_cnt == 2'd0) ? PH_SSRC : PH_PAD;
                    end
                end else begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                active = 1'b1;
                n_len  = b;
                if (!borrow && ({{(OFF_W-8){1'b0}}, b} > diff)) begin
                    fin    = 1'b1;
                    fin_st = ST_LEN_PAST;
                end else if (b == 8'd0) begin
                    emit    = 1'b1;
                    iend    = 1'b1;
                    n_phase = PH_TYPE;
                    if (at_end || last) fin = 1'b1;
                end else begin
                    n_rem   = b;
                    n_phase = PH_DATA;
                    if (last) begin
                        fin    = 1'b1;
                        fin_st = ST_BUF_CUT;
                    end
                end
            end
            PH_DATA: begin
                active = 1'b1;
                emit   = 1'b1;
                bval   = 1'b1;
                dbyte  = b;
                n_rem  = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    iend    = 1'b1;
                    n_phase = PH_TYPE;
                    if (at_end || last) fin = 1'b1;
                end else if (last) begin
                    fin    = 1'b1;
                    fin_st = ST_BUF_CUT;
                end
            end
            PH_PAD: begin
                active = 1'b1;
                n_rem  = r_rem - 8'd1;
                if (at_end || last) begin
                    fin = 1'b1;
                end else if (r_rem == 8'd1) begin
                    n_phase = PH_SSRC;
                end
            end
            default: begin
                // done: drop bytes until the buffer end
            end
        endcase

        if (fin) begin
            emit    = 1'b1;
            n_phase = PH_DONE;
        end
        if (active) n_off = r_off + OFF_W'(1);

        o_emit            = emit;
        o_res.chunk_ssrc  = n_ssrc;
        o_res.item_type   = n_type;
        o_res.item_length = n_len;
        o_res.data_byte   = dbyte;
        o_res.byte_valid  = bval;
        o_res.item_end    = iend;
        o_res.packet_done = fin;
        o_res.status      = fin_st;

        // buffer end: next byte opens a fresh packet
        if (last) begin
            n_off   = '0;
            n_lim   = '0;
            n_ctgt  = 5'd0;
            n_cseen = 5'd0;
            n_ssrc  = 32'd0;
            n_phase = PH_HDR;
            n_type  = 8'd0;
            n_len   = 8'd0;
            n_rem   = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_lim   <= '0;
            r_ctgt  <= 5'd0;
            r_cseen <= 5'd0;
            r_ssrc  <= 32'd0;
            r_phase <= PH_HDR;
            r_type  <= 8'd0;
            r_len   <= 8'd0;
            r_rem   <= 8'd0;
        end else if (i_fire) begin
            r_off   <= n_off;
            r_lim   <= n_lim;
            r_ctgt  <= n_ctgt;
            r_cseen <= n_cseen;
            r_ssrc  <= n_ssrc;
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

endmodule

>>> design/rsdes_skid.sv
// Two-entry result queue: output register plus skid slot.
// Depends on rsdes_pkg for the result struct.
module rsdes_skid
    import rsdes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic [1:0] r_cnt, n_cnt;
    t_out       r_head, r_tail;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_head;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) n_cnt = r_cnt + 2'd1;
        else if (!i_push && pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // payload slots: no reset
    always_ff @(posedge i_clk) begin
        if (i_push && pop) begin
            if (r_cnt == 2'd1) begin
                r_head <= i_data;
            end else begin
                r_head <= r_tail;
                r_tail <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) r_head <= i_data;
            else r_tail <= i_data;
        end else if (pop) begin
            r_head <= r_tail;
        end
    end

endmodule
